@@ rtl/boot_slot_priority_chooser_defines.svh @@
// Assertion macros used by the boot slot chooser checker.
`ifndef BOOT_SLOT_PRIORITY_CHOOSER_DEFINES_SVH
`define BOOT_SLOT_PRIORITY_CHOOSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bspc check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bspc check failed");

`endif

@@ rtl/bspc_pkg.sv @@
// Types, codes and constants of the boot slot priority chooser.
`timescale 1ns / 1ps
`default_nettype none
package bspc_pkg;

    localparam int NUM_TARGETS = 8;
    localparam int IDX_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
    localparam int KIND_W      = 3;
    localparam int ID_W        = 4;
    localparam int VAL_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD         = 3'd0,
        KIND_START        = 3'd1,
        KIND_CHOOSE       = 3'd2,
        KIND_SET_ATTEMPTS = 3'd3,
        KIND_SET_PRIORITY = 3'd4,
        KIND_QUERY        = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 2'd0,
        STS_NO_TARGET    = 2'd1,
        STS_BAD_ID       = 2'd2,
        STS_UNKNOWN_LAST = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISABLE_ON_ZERO  = 2'd0,
        CFG_ATT_ON_POWER_ON  = 2'd1,
        CFG_ATT_ALL_ZERO     = 2'd2,
        CFG_PRIO_ALL_ZERO    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   target_id;
        logic [VAL_W-1:0]  priority_req;
        logic [VAL_W-1:0]  attempts;
        logic [VAL_W-1:0]  base_priority;
        logic [VAL_W-1:0]  base_attempts;
        logic              use_default;
        logic              power_on_reset;
        logic              last_boot_ok;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     result_id;
        logic [VAL_W-1:0]    result_priority;
        logic [VAL_W-1:0]    result_attempts;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SET,
        S_START,
        S_SCAN_PRIO,
        S_RESTORE,
        S_FINISH,
        S_SEEK,
        S_DECR,
        S_RESP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_SET,
        OP_START,
        OP_SCAN_PRIO,
        OP_RESTORE,
        OP_FINISH,
        OP_SEEK,
        OP_DECR,
        OP_RESPOND
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic any_present;
        logic walk_last;
    } sts_t;

endpackage
`default_nettype wire

@@ rtl/bspc_ctrl.sv @@
// Sequencer of the boot slot chooser: walks the table passes and runs the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module bspc_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic [bspc_pkg::KIND_W-1:0] req_kind,
    output      logic                        req_ready,
    output      logic                        rsp_valid,
    input  wire logic                        rsp_ready,
    output      bspc_pkg::cmd_t              cmd,
    input  wire bspc_pkg::sts_t              sts
);

    bspc_pkg::state_t state_reg;
    bspc_pkg::state_t state_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             out_free;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == bspc_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bspc_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    case (bspc_pkg::kind_t'(req_kind))
                        bspc_pkg::KIND_LOAD:         state_next = bspc_pkg::S_LOAD;
                        bspc_pkg::KIND_START:        state_next = bspc_pkg::S_START;
                        bspc_pkg::KIND_CHOOSE:       state_next = bspc_pkg::S_SEEK;
                        bspc_pkg::KIND_SET_ATTEMPTS: state_next = bspc_pkg::S_SET;
                        bspc_pkg::KIND_SET_PRIORITY: state_next = bspc_pkg::S_SET;
                        bspc_pkg::KIND_QUERY:        state_next = bspc_pkg::S_SET;
                        default:                     state_next = bspc_pkg::S_RESP;
                    endcase
                end
            end
            bspc_pkg::S_LOAD:      state_next = bspc_pkg::S_RESP;
            bspc_pkg::S_SET:       state_next = bspc_pkg::S_RESP;
            bspc_pkg::S_START:
            begin
                state_next = sts.any_present ? bspc_pkg::S_SCAN_PRIO : bspc_pkg::S_RESP;
            end
            bspc_pkg::S_SCAN_PRIO:
            begin
                if (sts.walk_last)
                begin
                    state_next = bspc_pkg::S_RESTORE;
                end
            end
            bspc_pkg::S_RESTORE:
            begin
                if (sts.walk_last)
                begin
                    state_next = bspc_pkg::S_FINISH;
                end
            end
            bspc_pkg::S_FINISH:
            begin
                if (sts.walk_last)
                begin
                    state_next = bspc_pkg::S_RESP;
                end
            end
            bspc_pkg::S_SEEK:
            begin
                if (sts.walk_last)
                begin
                    state_next = bspc_pkg::S_DECR;
                end
            end
            bspc_pkg::S_DECR:      state_next = bspc_pkg::S_RESP;
            bspc_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    state_next = bspc_pkg::S_IDLE;
                end
            end
            default:               state_next = bspc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = bspc_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        case (state_reg)
            bspc_pkg::S_IDLE:      cmd.op = req_valid ? bspc_pkg::OP_CAPTURE : bspc_pkg::OP_NONE;
            bspc_pkg::S_LOAD:      cmd.op = bspc_pkg::OP_LOAD;
            bspc_pkg::S_SET:       cmd.op = bspc_pkg::OP_SET;
            bspc_pkg::S_START:     cmd.op = bspc_pkg::OP_START;
            bspc_pkg::S_SCAN_PRIO: cmd.op = bspc_pkg::OP_SCAN_PRIO;
            bspc_pkg::S_RESTORE:   cmd.op = bspc_pkg::OP_RESTORE;
            bspc_pkg::S_FINISH:    cmd.op = bspc_pkg::OP_FINISH;
            bspc_pkg::S_SEEK:      cmd.op = bspc_pkg::OP_SEEK;
            bspc_pkg::S_DECR:      cmd.op = bspc_pkg::OP_DECR;
            bspc_pkg::S_RESP:
            begin
                cmd.op       = bspc_pkg::OP_RESPOND;
                cmd.out_load = out_free;
            end
            default:               cmd.op = bspc_pkg::OP_NONE;
        endcase
    end

    // Hold the result until taken; a new one may replace it in the same cycle.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bspc_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/bspc_dpath.sv @@
// Datapath of the boot slot chooser: target table, walk pointer, flags and result register.
`timescale 1ns / 1ps
`default_nettype none
module bspc_dpath
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bspc_pkg::req_t                 req,
    input  wire logic                           cfg_we,
    input  wire logic [bspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data,
    input  wire bspc_pkg::cmd_t                 cmd,
    output      bspc_pkg::sts_t                 sts,
    output      bspc_pkg::rsp_t                 rsp
);

    localparam int N  = bspc_pkg::NUM_TARGETS;
    localparam int IW = bspc_pkg::IDX_W;
    localparam int DW = bspc_pkg::ID_W;
    localparam int VW = bspc_pkg::VAL_W;

    // Target table
    logic [N-1:0]  present_reg;
    logic [VW-1:0] prio_reg     [N];
    logic [VW-1:0] att_reg      [N];
    logic [VW-1:0] dflt_prio_reg[N];
    logic [VW-1:0] dflt_att_reg [N];
    logic [VW-1:0] key_reg      [N];

    // Configuration
    logic cfg_dis_zero_reg;
    logic cfg_att_po_reg;
    logic cfg_att_zero_reg;
    logic cfg_prio_zero_reg;

    logic                          power_on_done_reg, power_on_done_next;
    bspc_pkg::req_t                item_reg, item_next;
    logic [IW-1:0]                 ptr_reg, ptr_next;
    logic [IW-1:0]                 best_idx_reg, best_idx_next;
    logic [VW-1:0]                 best_key_reg, best_key_next;
    logic                          found_reg, found_next;
    logic                          prio_nz_reg, prio_nz_next;
    logic                          att_nz_reg, att_nz_next;
    logic [bspc_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          res_none_reg, res_none_next;
    logic [IW-1:0]                 sel_reg, sel_next;
    bspc_pkg::rsp_t                rsp_reg, rsp_next;

    // Single write port into the table
    logic          wr_en;
    logic          ld_en;
    logic [IW-1:0] wr_idx;
    logic [VW-1:0] wr_prio;
    logic [VW-1:0] wr_att;

    logic [DW-1:0] id;
    logic          in_range;
    logic [IW-1:0] slot;
    logic          slot_present;
    logic [IW-1:0] rd_idx;
    logic          rd_present;
    logic [VW-1:0] rd_prio;
    logic [VW-1:0] rd_att;
    logic [VW-1:0] rd_dprio;
    logic [VW-1:0] rd_datt;
    logic [VW-1:0] rd_key;
    logic          walk_last;
    logic          restore_po;
    logic          prio_reset;
    logic [VW-1:0] p1, a1, a2, p2;
    logic          cand;

    assign id           = item_reg.target_id;
    assign in_range     = (id != '0) && (id <= DW'(N));
    assign slot         = IW'(id - DW'(1));
    assign slot_present = in_range && present_reg[slot];
    assign walk_last    = (ptr_reg == IW'(N - 1));
    assign restore_po   = cfg_att_po_reg && item_reg.power_on_reset && !power_on_done_reg;
    assign prio_reset   = cfg_prio_zero_reg && !prio_nz_reg;

    always_comb
    begin
        case (cmd.op)
            bspc_pkg::OP_LOAD:    rd_idx = slot;
            bspc_pkg::OP_SET:     rd_idx = slot;
            bspc_pkg::OP_DECR:    rd_idx = best_idx_reg;
            bspc_pkg::OP_RESPOND: rd_idx = sel_reg;
            default:              rd_idx = ptr_reg;
        endcase
    end

    assign rd_present = present_reg[rd_idx];
    assign rd_prio    = prio_reg[rd_idx];
    assign rd_att     = att_reg[rd_idx];
    assign rd_dprio   = dflt_prio_reg[rd_idx];
    assign rd_datt    = dflt_att_reg[rd_idx];
    assign rd_key     = key_reg[rd_idx];

    assign sts.any_present = |present_reg;
    assign sts.walk_last   = walk_last;
    assign rsp             = rsp_reg;

    // Per-entry values of the start passes
    always_comb
    begin
        p1 = (prio_reset && rd_present) ? rd_dprio : rd_prio;
        a1 = (restore_po && rd_present && (p1 != '0)) ? rd_datt : rd_att;
        a2 = (cfg_att_zero_reg && !att_nz_reg && rd_present && (rd_prio != '0))
             ? rd_datt : rd_att;
        if (slot_present && item_reg.last_boot_ok && (ptr_reg == slot))
        begin
            a2 = rd_datt;
        end
        p2   = (cfg_dis_zero_reg && rd_present && (a2 == '0)) ? '0 : rd_prio;
        cand = rd_present && (rd_prio != '0) && (rd_att != '0);
    end

    always_comb
    begin
        item_next          = item_reg;
        ptr_next           = ptr_reg;
        best_idx_next      = best_idx_reg;
        best_key_next      = best_key_reg;
        found_next         = found_reg;
        prio_nz_next       = prio_nz_reg;
        att_nz_next        = att_nz_reg;
        res_status_next    = res_status_reg;
        res_none_next      = res_none_reg;
        sel_next           = sel_reg;
        power_on_done_next = power_on_done_reg;
        rsp_next           = rsp_reg;
        wr_en              = 1'b0;
        ld_en              = 1'b0;
        wr_idx             = rd_idx;
        wr_prio            = rd_prio;
        wr_att             = rd_att;

        case (cmd.op)
            bspc_pkg::OP_CAPTURE:
            begin
                item_next       = req;
                ptr_next        = '0;
                found_next      = 1'b0;
                prio_nz_next    = 1'b0;
                att_nz_next     = 1'b0;
                res_status_next = bspc_pkg::STS_BAD_ID;
                res_none_next   = 1'b1;
                sel_next        = '0;
            end
            bspc_pkg::OP_LOAD:
            begin
                if (in_range)
                begin
                    wr_en           = 1'b1;
                    ld_en           = 1'b1;
                    wr_prio         = item_reg.priority_req;
                    wr_att          = (item_reg.priority_req != '0) ? item_reg.attempts : '0;
                    res_status_next = bspc_pkg::STS_OK;
                    res_none_next   = 1'b0;
                    sel_next        = slot;
                end
            end
            bspc_pkg::OP_SET:
            begin
                if (slot_present)
                begin
                    res_status_next = bspc_pkg::STS_OK;
                    res_none_next   = 1'b0;
                    sel_next        = slot;
                    case (bspc_pkg::kind_t'(item_reg.kind))
                        bspc_pkg::KIND_SET_ATTEMPTS:
                        begin
                            wr_en  = 1'b1;
                            wr_att = item_reg.use_default ? rd_datt : item_reg.attempts;
                        end
                        bspc_pkg::KIND_SET_PRIORITY:
                        begin
                            wr_en   = 1'b1;
                            wr_prio = item_reg.use_default ? rd_dprio : item_reg.priority_req;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            bspc_pkg::OP_START:
            begin
                if (!sts.any_present)
                begin
                    res_status_next = bspc_pkg::STS_NO_TARGET;
                    res_none_next   = 1'b1;
                end
            end
            bspc_pkg::OP_SCAN_PRIO:
            begin
                prio_nz_next = prio_nz_reg || (rd_present && (rd_prio != '0));
                ptr_next     = walk_last ? '0 : ptr_reg + IW'(1);
            end
            bspc_pkg::OP_RESTORE:
            begin
                wr_en       = rd_present;
                wr_prio     = p1;
                wr_att      = a1;
                att_nz_next = att_nz_reg || (rd_present && (a1 != '0));
                ptr_next    = walk_last ? '0 : ptr_reg + IW'(1);
                // Power-on restore happens once until reset
                if (walk_last && restore_po)
                begin
                    power_on_done_next = 1'b1;
                end
            end
            bspc_pkg::OP_FINISH:
            begin
                wr_en    = rd_present;
                wr_prio  = p2;
                wr_att   = a2;
                ptr_next = walk_last ? '0 : ptr_reg + IW'(1);
                if (walk_last)
                begin
                    sel_next = slot;
                    if ((id != '0) && !slot_present)
                    begin
                        res_status_next = bspc_pkg::STS_UNKNOWN_LAST;
                        res_none_next   = 1'b1;
                    end
                    else
                    begin
                        res_status_next = bspc_pkg::STS_OK;
                        res_none_next   = !slot_present;
                    end
                end
            end
            bspc_pkg::OP_SEEK:
            begin
                // Strictly greater key wins, so ties keep the lower id
                if (cand && (!found_reg || (rd_key > best_key_reg)))
                begin
                    found_next    = 1'b1;
                    best_idx_next = ptr_reg;
                    best_key_next = rd_key;
                end
                ptr_next = walk_last ? '0 : ptr_reg + IW'(1);
            end
            bspc_pkg::OP_DECR:
            begin
                if (found_reg)
                begin
                    wr_en           = 1'b1;
                    wr_att          = rd_att - VW'(1);
                    res_status_next = bspc_pkg::STS_OK;
                    res_none_next   = 1'b0;
                    sel_next        = best_idx_reg;
                end
                else
                begin
                    res_status_next = bspc_pkg::STS_NO_TARGET;
                    res_none_next   = 1'b1;
                end
            end
            bspc_pkg::OP_RESPOND:
            begin
                if (cmd.out_load)
                begin
                    rsp_next.status = res_status_reg;
                    if (res_none_reg)
                    begin
                        rsp_next.result_id       = '0;
                        rsp_next.result_priority = '0;
                        rsp_next.result_attempts = '0;
                    end
                    else
                    begin
                        rsp_next.result_id       = DW'(sel_reg) + DW'(1);
                        rsp_next.result_priority = rd_prio;
                        rsp_next.result_attempts = rd_att;
                    end
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg       <= '0;
            power_on_done_reg <= 1'b0;
            cfg_dis_zero_reg  <= 1'b0;
            cfg_att_po_reg    <= 1'b0;
            cfg_att_zero_reg  <= 1'b0;
            cfg_prio_zero_reg <= 1'b0;
            ptr_reg           <= '0;
            found_reg         <= 1'b0;
            prio_nz_reg       <= 1'b0;
            att_nz_reg        <= 1'b0;
            res_status_reg    <= bspc_pkg::STS_OK;
            res_none_reg      <= 1'b1;
            sel_reg           <= '0;
            best_idx_reg      <= '0;
        end
        else
        begin
            if (ld_en)
            begin
                present_reg[wr_idx] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (bspc_pkg::cfg_reg_t'(cfg_index))
                    bspc_pkg::CFG_DISABLE_ON_ZERO: cfg_dis_zero_reg  <= cfg_data;
                    bspc_pkg::CFG_ATT_ON_POWER_ON: cfg_att_po_reg    <= cfg_data;
                    bspc_pkg::CFG_ATT_ALL_ZERO:    cfg_att_zero_reg  <= cfg_data;
                    bspc_pkg::CFG_PRIO_ALL_ZERO:   cfg_prio_zero_reg <= cfg_data;
                    default:                       cfg_dis_zero_reg  <= cfg_dis_zero_reg;
                endcase
            end
            power_on_done_reg <= power_on_done_next;
            ptr_reg           <= ptr_next;
            found_reg         <= found_next;
            prio_nz_reg       <= prio_nz_next;
            att_nz_reg        <= att_nz_next;
            res_status_reg    <= res_status_next;
            res_none_reg      <= res_none_next;
            sel_reg           <= sel_next;
            best_idx_reg      <= best_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        best_key_reg <= best_key_next;
        rsp_reg      <= rsp_next;
        for (int i = 0; i < N; i++)
        begin
            if (wr_en && (wr_idx == IW'(i)))
            begin
                prio_reg[i] <= wr_prio;
                att_reg[i]  <= wr_att;
            end
            if (ld_en && (wr_idx == IW'(i)))
            begin
                dflt_prio_reg[i] <= item_reg.base_priority;
                dflt_att_reg[i]  <= item_reg.base_attempts;
                key_reg[i]       <= item_reg.priority_req;
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/boot_slot_priority_chooser.sv @@
// Top level of the boot slot priority chooser.
//
// Requests arrive on req (valid/ready) and each produces exactly one
// response transaction on rsp (valid/ready). Configuration bits are written
// through cfg_we/cfg_index/cfg_data while no request is in flight; the user
// must keep to this, as the block itself does not enforce it.
// One request is worked at a time; req_ready is high only while idle.
// After acceptance, an unused kind goes straight to the response; load,
// set and query make one table access and then respond; choose walks the
// table (one entry per cycle over NUM_TARGETS entries) and then decrements
// the attempts of the target it picks; start walks it in a priority scan,
// a restore and a finish pass, or goes straight to the response on an
// empty table.
// The next request can be taken in the cycle after the response is registered.
// The response sits in an output register: a stalled receiver holds it
// there while the next request is accepted and worked; that request's
// response waits until the register is free.
// Reset (rst_n low, asynchronous) empties the table, clears the power-on
// flag and configuration, and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none
module boot_slot_priority_chooser
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output      logic                           req_ready,
    input  wire bspc_pkg::req_t                 req,
    output      logic                           rsp_valid,
    input  wire logic                           rsp_ready,
    output      bspc_pkg::rsp_t                 rsp,
    input  wire logic                           cfg_we,
    input  wire logic [bspc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic                           cfg_data
);

    bspc_pkg::cmd_t cmd;
    bspc_pkg::sts_t sts;

    bspc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bspc_dpath u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

@@ rtl/bspc_chk.sv @@
// Port checker for the boot slot priority chooser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "boot_slot_priority_chooser_defines.svh"
module bspc_chk
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire bspc_pkg::rsp_t rsp
);

    // A stalled response keeps its payload
    `BSPC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // Only one request in work: after an accept, no accept in the next cycle
    `BSPC_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // Any failing status carries no target
    `BSPC_ASSERT_IMP(a_fail_empty,
        rsp_valid && (rsp.status != bspc_pkg::STS_OK),
        (rsp.result_id == '0) && (rsp.result_priority == '0) && (rsp.result_attempts == '0))

    // A named target is always within the table
    `BSPC_ASSERT_IMP(a_id_range,
        rsp_valid && (rsp.result_id != '0),
        rsp.result_id <= bspc_pkg::ID_W'(bspc_pkg::NUM_TARGETS))

endmodule

bind boot_slot_priority_chooser bspc_chk u_bspc_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
`default_nettype wire

@@ test/boot_slot_priority_chooser_test.sv @@
// Testbench for the boot slot priority chooser: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module boot_slot_priority_chooser_test;
    import bspc_pkg::*;

    localparam int              LIMIT_CYCLES  = 1_000_000;
    localparam int              HOLD_CYCLES   = 500;
    localparam int              TAIL_CYCLES   = 40;
    localparam logic [ID_W-1:0] MAX_ID        = '1;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic                 cfg_data  = 1'b0;

    // Boot table as the block should hold it
    logic             tgt_on    [NUM_TARGETS];
    logic [VAL_W-1:0] tgt_prio  [NUM_TARGETS];
    logic [VAL_W-1:0] tgt_att   [NUM_TARGETS];
    logic [VAL_W-1:0] tgt_dprio [NUM_TARGETS];
    logic [VAL_W-1:0] tgt_datt  [NUM_TARGETS];
    logic [VAL_W-1:0] tgt_key   [NUM_TARGETS];
    logic [ID_W-1:0]  last_pick = '0;
    bit               power_on_used = 1'b0;
    logic [3:0]       cfg_now = '0;

    rsp_t expected_rsp_q [$];
    int   mismatch_count  = 0;
    int   rsp_count       = 0;
    int   items_accepted  = 0;
    int   cycle_count     = 0;
    int   send_idle_pct   = 0;
    int   stall_pct       = 0;
    logic hold_go         = 1'b0;
    int   hold_count      = 0;
    logic receiver_holding;

    boot_slot_priority_chooser dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("boot_slot_priority_chooser: mismatch");
            $finish;
        end
    end

    // Long receiver hold-off, counted here once the test raises hold_go
    always @(posedge clk)
    begin
        if (!hold_go)
            hold_count <= 0;
        else if (hold_count < HOLD_CYCLES)
            hold_count <= hold_count + 1;
    end

    assign receiver_holding = hold_go && (hold_count < HOLD_CYCLES);

    always @(posedge clk)
    begin
        rsp_ready <= !receiver_holding && ($urandom_range(99) >= stall_pct);
    end

    function automatic int present_slot(input logic [ID_W-1:0] id);
        if (id >= 1 && id <= NUM_TARGETS)
        begin
            if (tgt_on[id - 1])
                return id - 1;
        end
        return -1;
    endfunction

    function automatic void restore_enabled_attempts();
        for (int i = 0; i < NUM_TARGETS; i++)
            if (tgt_on[i] && tgt_prio[i] != 0)
                tgt_att[i] = tgt_datt[i];
    endfunction

    // Apply one request to the table and return the response it must produce
    function automatic rsp_t predict_rsp(input req_t item);
        int      slot;
        int      best;
        bit      found;
        status_t st;
        rsp_t    res;
        slot = -1;
        st   = STS_OK;
        case (item.kind)
            KIND_LOAD:
            begin
                if (item.target_id >= 1 && item.target_id <= NUM_TARGETS)
                begin
                    slot = item.target_id - 1;
                    tgt_on[slot]    = 1'b1;
                    tgt_dprio[slot] = item.base_priority;
                    tgt_datt[slot]  = item.base_attempts;
                    tgt_prio[slot]  = item.priority_req;
                    tgt_att[slot]   = (item.priority_req != 0) ? item.attempts : '0;
                    tgt_key[slot]   = item.priority_req;
                end
                else
                    st = STS_BAD_ID;
            end
            KIND_START:
            begin
                found = 1'b0;
                for (int i = 0; i < NUM_TARGETS; i++)
                    if (tgt_on[i])
                        found = 1'b1;
                if (!found)
                    st = STS_NO_TARGET;
                else
                begin
                    if (cfg_now[CFG_PRIO_ALL_ZERO])
                    begin
                        found = 1'b0;
                        for (int i = 0; i < NUM_TARGETS; i++)
                            if (tgt_on[i] && tgt_prio[i] != 0)
                                found = 1'b1;
                        if (!found)
                            for (int i = 0; i < NUM_TARGETS; i++)
                                if (tgt_on[i])
                                    tgt_prio[i] = tgt_dprio[i];
                    end
                    if (cfg_now[CFG_ATT_ON_POWER_ON] && item.power_on_reset && !power_on_used)
                    begin
                        restore_enabled_attempts();
                        power_on_used = 1'b1;
                    end
                    if (cfg_now[CFG_ATT_ALL_ZERO])
                    begin
                        found = 1'b0;
                        for (int i = 0; i < NUM_TARGETS; i++)
                            if (tgt_on[i] && tgt_att[i] != 0)
                                found = 1'b1;
                        if (!found)
                            restore_enabled_attempts();
                    end
                    slot = present_slot(item.target_id);
                    last_pick = (slot >= 0) ? ID_W'(slot + 1) : '0;
                    if (slot >= 0 && item.last_boot_ok)
                        tgt_att[slot] = tgt_datt[slot];
                    if (cfg_now[CFG_DISABLE_ON_ZERO])
                        for (int i = 0; i < NUM_TARGETS; i++)
                            if (tgt_on[i] && tgt_att[i] == 0)
                                tgt_prio[i] = '0;
                    if (item.target_id != 0 && slot < 0)
                        st = STS_UNKNOWN_LAST;
                end
            end
            KIND_CHOOSE:
            begin
                best = -1;
                // strict compare keeps the lower id on equal keys
                for (int i = 0; i < NUM_TARGETS; i++)
                    if (tgt_on[i] && tgt_prio[i] != 0 && tgt_att[i] != 0
                        && (best < 0 || tgt_key[i] > tgt_key[best]))
                        best = i;
                if (best < 0)
                    st = STS_NO_TARGET;
                else
                begin
                    tgt_att[best] = tgt_att[best] - 1'b1;
                    last_pick = ID_W'(best + 1);
                    slot = best;
                end
            end
            KIND_SET_ATTEMPTS, KIND_SET_PRIORITY, KIND_QUERY:
            begin
                slot = present_slot(item.target_id);
                if (slot < 0)
                    st = STS_BAD_ID;
                else if (item.kind == KIND_SET_ATTEMPTS)
                    tgt_att[slot] = item.use_default ? tgt_datt[slot] : item.attempts;
                else if (item.kind == KIND_SET_PRIORITY)
                    tgt_prio[slot] = item.use_default ? tgt_dprio[slot] : item.priority_req;
            end
            default:
                st = STS_BAD_ID;
        endcase
        res = '0;
        res.status = st;
        if (slot >= 0)
        begin
            res.result_id       = ID_W'(slot + 1);
            res.result_priority = tgt_prio[slot];
            res.result_attempts = tgt_att[slot];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("rsp %0d: %s got %0h expected %0h", rsp_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp_q.size() == 0)
                report_mismatch("unexpected transaction, status", rsp.status, '0);
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.result_id !== want.result_id)
                    report_mismatch("result_id", rsp.result_id, want.result_id);
                if (rsp.result_priority !== want.result_priority)
                    report_mismatch("result_priority", rsp.result_priority,
                                    want.result_priority);
                if (rsp.result_attempts !== want.result_attempts)
                    report_mismatch("result_attempts", rsp.result_attempts,
                                    want.result_attempts);
            end
            rsp_count++;
        end
    end

    // Offer one transaction; valid stays up into the next call unless a gap is drawn
    task automatic send_item(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsp_q.push_back(predict_rsp(item));
        items_accepted++;
    endtask

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                         input logic [VAL_W-1:0] prio, input logic [VAL_W-1:0] att,
                         input logic [VAL_W-1:0] dprio, input logic [VAL_W-1:0] datt,
                         input logic use_def, input logic por, input logic boot_ok);
        req_t item;
        item                = '0;
        item.kind           = kind;
        item.target_id      = id;
        item.priority_req   = prio;
        item.attempts       = att;
        item.base_priority  = dprio;
        item.base_attempts  = datt;
        item.use_default    = use_def;
        item.power_on_reset = por;
        item.last_boot_ok   = boot_ok;
        send_item(item);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers back to back; bit n goes to register n
    task automatic set_config(input logic [3:0] bits);
        cfg_reg_t reg_sel;
        reg_sel = reg_sel.first();
        repeat (reg_sel.num())
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_sel;
            cfg_data  <= bits[reg_sel];
            @(posedge clk);
            cfg_now[reg_sel] = bits[reg_sel];
            reg_sel = reg_sel.next();
        end
        cfg_we <= 1'b0;
    endtask

    function automatic req_t rand_fields();
        logic [63:0] bits;
        req_t        item;
        bits = {$urandom, $urandom};
        item = bits[$bits(req_t)-1:0];
        return item;
    endfunction

    // Favor zero, tiny values and all-ones so ties and exhausted targets show up
    function automatic logic [VAL_W-1:0] pick_val();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return '0;
        if (roll < 50)
            return VAL_W'($urandom_range(3, 1));
        if (roll < 60)
            return '1;
        return VAL_W'($urandom_range(255));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return ID_W'($urandom_range(NUM_TARGETS, 1));
        if (roll < 92)
            return '0;
        return ID_W'($urandom_range(MAX_ID, NUM_TARGETS + 1));
    endfunction

    task automatic drive_random_items(input int count);
        int   stop_at;
        int   roll;
        bit   zero_prio;
        bit   zero_att;
        req_t item;
        stop_at = items_accepted + count;
        while (items_accepted < stop_at)
        begin
            roll = $urandom_range(99);
            item = rand_fields();
            if (roll < 4)
            begin
                // knock every target down to zero, then start, to reach the all-zero rules
                zero_prio = $urandom_range(1);
                zero_att  = !zero_prio || $urandom_range(1);
                for (int id = 1; id <= NUM_TARGETS; id++)
                begin
                    if (zero_prio)
                    begin
                        item              = rand_fields();
                        item.kind         = KIND_SET_PRIORITY;
                        item.target_id    = ID_W'(id);
                        item.priority_req = '0;
                        item.use_default  = 1'b0;
                        send_item(item);
                    end
                    if (zero_att)
                    begin
                        item             = rand_fields();
                        item.kind        = KIND_SET_ATTEMPTS;
                        item.target_id   = ID_W'(id);
                        item.attempts    = '0;
                        item.use_default = 1'b0;
                        send_item(item);
                    end
                end
                item           = rand_fields();
                item.kind      = KIND_START;
                item.target_id = pick_id();
                send_item(item);
            end
            else
            begin
                if (roll < 16)
                    item.kind = KIND_LOAD;
                else if (roll < 32)
                    item.kind = KIND_START;
                else if (roll < 66)
                    item.kind = KIND_CHOOSE;
                else if (roll < 78)
                    item.kind = KIND_SET_ATTEMPTS;
                else if (roll < 88)
                    item.kind = KIND_SET_PRIORITY;
                else if (roll < 96)
                    item.kind = KIND_QUERY;
                else
                    item.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
                item.target_id     = pick_id();
                item.priority_req  = pick_val();
                item.attempts      = pick_val();
                item.base_priority = pick_val();
                item.base_attempts = pick_val();
                send_item(item);
            end
        end
    endtask

    task automatic test_empty_table();
        issue(KIND_START, 4'd3, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1);
        issue(KIND_CHOOSE, '0, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
        issue(KIND_QUERY, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_LOAD, '0, 8'd5, 8'd5, 8'd5, 8'd5, 1'b0, 1'b0, 1'b0);
        issue(KIND_LOAD, MAX_ID, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
        issue(KIND_SPARE_LO, 4'd1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
        issue(KIND_SPARE_HI, 4'd2, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_table_ops();
        issue(KIND_LOAD, 4'd1, '1, '1, '1, '1, 1'b0, 1'b0, 1'b0);
        // zero priority forces the stored attempts to zero
        issue(KIND_LOAD, 4'd8, '0, 8'd7, 8'd3, 8'd1, 1'b0, 1'b0, 1'b0);
        // same sort key as target 1: the lower id wins
        issue(KIND_LOAD, 4'd2, '1, 8'd1, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_CHOOSE, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_ATTEMPTS, 4'd1, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_CHOOSE, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_CHOOSE, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_PRIORITY, 4'd9, 8'd4, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_PRIORITY, 4'd8, 8'd9, '0, '0, '0, 1'b1, 1'b0, 1'b0);
        issue(KIND_QUERY, 4'd8, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_START, 4'd5, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        drain_responses();
    endtask

    task automatic test_start_rules();
        set_config(4'b1111);
        issue(KIND_START, 4'd1, '0, '0, '0, '0, 1'b0, 1'b1, 1'b1);
        // power-on restore must not repeat
        issue(KIND_START, '0, '0, '0, '0, '0, 1'b0, 1'b1, 1'b0);
        issue(KIND_SET_PRIORITY, 4'd1, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_PRIORITY, 4'd8, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_ATTEMPTS, 4'd1, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_ATTEMPTS, 4'd8, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_START, 4'd2, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
        issue(KIND_SET_ATTEMPTS, 4'd2, '0, 8'd6, '0, '0, 1'b1, 1'b0, 1'b0);
        drain_responses();
    endtask

    task automatic test_random_traffic(input logic [3:0] cfg_bits, input int idle_pct,
                                       input int stall, input int count);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        set_config(cfg_bits);
        drive_random_items(count);
        drain_responses();
    endtask

    task automatic test_receiver_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_config(4'($urandom_range(15)));
        hold_go <= 1'b1;
        drive_random_items(120);
        drain_responses();
        hold_go <= 1'b0;
    endtask

    initial
    begin
        for (int i = 0; i < NUM_TARGETS; i++)
        begin
            tgt_on[i]    = 1'b0;
            tgt_prio[i]  = '0;
            tgt_att[i]   = '0;
            tgt_dprio[i] = '0;
            tgt_datt[i]  = '0;
            tgt_key[i]   = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(4'b0000);
        test_empty_table();
        test_table_ops();
        test_start_rules();
        test_random_traffic(4'b0000, 0, 0, 350);
        test_random_traffic(4'($urandom_range(15)), 67, 0, 350);
        test_random_traffic(4'b1111, 0, 67, 350);
        test_random_traffic(4'($urandom_range(15)), 7, 7, 350);
        test_receiver_backpressure();
        test_random_traffic(4'($urandom_range(15)), 67, 67, 150);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("boot_slot_priority_chooser: match");
        else
            $display("boot_slot_priority_chooser: mismatch");
        $finish;
    end

endmodule

@@ boot_slot_priority_chooser.f @@
+incdir+rtl
rtl/bspc_pkg.sv
rtl/bspc_ctrl.sv
rtl/bspc_dpath.sv
rtl/boot_slot_priority_chooser.sv
rtl/bspc_chk.sv
test/boot_slot_priority_chooser_test.sv
